FILE: hdl/pffla_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared widths, operation codes and the item carried from front to back.
// ----------------------------------------------------------------------------
package pffla_pkg;

  localparam int FRAMES      = 1024;
  localparam int PAGE_SHIFT  = 12;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int ADDR_W      = 32;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 11;
  localparam int TOP_W       = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOP_W-1:0] TOP_RESET = TOP_W'(1024);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic [MODE_W-1:0] MODE_REGISTER = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ALLOC    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_FREE     = MODE_W'(2);

  localparam logic [KIND_W-1:0] KIND_RESERVED = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_USED     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_FREE     = KIND_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_OK          = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_EMPTY       = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR    = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE  = STATUS_W'(3);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BAD,
    OP_REG_USED,
    OP_REG_FREE,
    OP_ALLOC,
    OP_FREE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/page_frame_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator
// Keeps physical page frames on a linked free list and serves register,
// allocate and free commands.
// ----------------------------------------------------------------------------
// Input: drive in_mode, in_address, in_frame_kind with start high; the item
// is taken at an edge where busy is low. The front end classifies it and
// places it in a two-entry queue; the back end executes items in order.
// Result: out_valid is high for exactly one cycle per item with
// out_alloc_address, out_status, out_free_count and out_used_count. The
// receiver cannot stall; every strobe must be captured.
// Flow: the accepted item is written into the queue; the back end pops it
// when idle, executes it and registers the result strobe. It takes no new
// item until the last is done; registering a free frame adds a link state,
// since the link memory has a single write port and a registered read.
// Configuration: cfg_we with cfg_data writes the memory top frame; write it
// only while no item is in flight.
// Reset: synchronous, active low. After reset the in-use memory is cleared
// in a pass over every frame while busy stays high.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pffla_pkg::MODE_W-1:0]   in_mode,
  input  logic [pffla_pkg::ADDR_W-1:0]   in_address,
  input  logic [pffla_pkg::KIND_W-1:0]   in_frame_kind,
  input  logic                           cfg_we,
  input  logic [pffla_pkg::TOP_W-1:0]    cfg_data,
  output logic                           out_valid,
  output logic [pffla_pkg::ADDR_W-1:0]   out_alloc_address,
  output logic [pffla_pkg::STATUS_W-1:0] out_status,
  output logic [pffla_pkg::CNT_W-1:0]    out_free_count,
  output logic [pffla_pkg::CNT_W-1:0]    out_used_count
);
  import pffla_pkg::*;

  item_t   front_item;
  item_t   head_item;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    clearing;

  assign busy = q_stat.full | clearing;
  assign push = start & ~busy;

  pffla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mode       (in_mode),
    .address    (in_address),
    .frame_kind (in_frame_kind),
    .item       (front_item)
  );

  pffla_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  pffla_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .stat              (q_stat),
    .head_item         (head_item),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_alloc_address (out_alloc_address),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .out_used_count    (out_used_count)
  );

endmodule

FILE: hdl/pffla_front.sv
// ----------------------------------------------------------------------------
// Page frame allocator front end
// Holds the memory top register, checks addresses and classifies each item.
// ----------------------------------------------------------------------------
module pffla_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pffla_pkg::TOP_W-1:0]    cfg_data,
  input  logic [pffla_pkg::MODE_W-1:0]   mode,
  input  logic [pffla_pkg::ADDR_W-1:0]   address,
  input  logic [pffla_pkg::KIND_W-1:0]   frame_kind,
  output pffla_pkg::item_t               item
);
  import pffla_pkg::*;

  logic [TOP_W-1:0]             top_r;
  logic [ADDR_W-PAGE_SHIFT-1:0] page;
  logic                         frame_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TOP_RESET;
    end else if (cfg_we) begin
      top_r <= cfg_data;
    end
  end

  assign page     = address[ADDR_W-1:PAGE_SHIFT];
  assign frame_ok = (address[PAGE_SHIFT-1:0] == '0) && (page != '0) &&
                    (ADDR_W'(page) < ADDR_W'(top_r)) && (ADDR_W'(page) < ADDR_W'(FRAMES));

  always_comb begin
    item.frame = page[FRAME_W-1:0];
    case (mode)
      MODE_REGISTER: begin
        case (frame_kind)
          KIND_USED: item.op = frame_ok ? OP_REG_USED : OP_BAD;
          KIND_FREE: item.op = frame_ok ? OP_REG_FREE : OP_BAD;
          default:   item.op = OP_NONE;
        endcase
      end
      MODE_ALLOC: item.op = OP_ALLOC;
      MODE_FREE:  item.op = frame_ok ? OP_FREE : OP_BAD;
      default:    item.op = OP_BAD;
    endcase
  end

endmodule

FILE: hdl/pffla_queue.sv
// ----------------------------------------------------------------------------
// Page frame allocator item queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module pffla_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pffla_pkg::item_t   push_item,
  input  logic               pop,
  output pffla_pkg::item_t   head_item,
  output pffla_pkg::q_stat_t stat
);
  import pffla_pkg::*;

  item_t             q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ptr_inc(wp_r);
      end
      if (pop) begin
        rp_r <= ptr_inc(rp_r);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head_item  = q_r[rp_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: hdl/pffla_back.sv
// ----------------------------------------------------------------------------
// Page frame allocator back end
// Owns the link and in-use memories, the list pointers and the counts.
// ----------------------------------------------------------------------------
module pffla_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pffla_pkg::q_stat_t             stat,
  input  pffla_pkg::item_t               head_item,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_valid,
  output logic [pffla_pkg::ADDR_W-1:0]   out_alloc_address,
  output logic [pffla_pkg::STATUS_W-1:0] out_status,
  output logic [pffla_pkg::CNT_W-1:0]    out_free_count,
  output logic [pffla_pkg::CNT_W-1:0]    out_used_count
);
  import pffla_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  state_t               state_r, state_nxt;
  logic [FRAME_W-1:0]   clr_r, clr_nxt;
  item_t                cur_r, cur_nxt;
  logic [FRAME_W-1:0]   head_r, head_nxt;
  logic [FRAME_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_alloc_address_r, out_alloc_address_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_free_count_r, out_free_count_nxt;
  logic [CNT_W-1:0]     out_used_count_r, out_used_count_nxt;

  logic                 use_mem [FRAMES];
  logic [FRAME_W-1:0]   link_mem [FRAMES];
  logic                 use_we, use_wd, use_q;
  logic [FRAME_W-1:0]   use_wa, use_ra;
  logic                 link_we;
  logic [FRAME_W-1:0]   link_wa, link_wd, link_ra, link_q;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - CNT_W'(1) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_q <= use_mem[use_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  always_comb begin
    state_nxt             = state_r;
    clr_nxt               = clr_r;
    cur_nxt               = cur_r;
    head_nxt              = head_r;
    tail_nxt              = tail_r;
    free_nxt              = free_r;
    used_nxt              = used_r;
    out_valid_nxt         = 1'b0;
    out_alloc_address_nxt = '0;
    out_status_nxt        = STATUS_OK;
    out_free_count_nxt    = out_free_count_r;
    out_used_count_nxt    = out_used_count_r;
    pop                   = 1'b0;
    use_we                = 1'b0;
    use_wa                = cur_r.frame;
    use_wd                = 1'b0;
    use_ra                = head_item.frame;
    link_we               = 1'b0;
    link_wa               = cur_r.frame;
    link_wd               = '0;
    link_ra               = head_r;
    case (state_r)
      S_CLEAR: begin
        use_we  = 1'b1;
        use_wa  = clr_r;
        clr_nxt = clr_r + FRAME_W'(1);
        if (clr_r == FRAME_W'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!stat.empty) begin
          pop       = 1'b1;
          cur_nxt   = head_item;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (cur_r.op)
          OP_NONE: begin
            out_status_nxt = STATUS_OK;
          end
          OP_REG_USED: begin
            if (use_q) begin
              out_status_nxt = STATUS_BAD_ADDR;
            end else begin
              use_we   = 1'b1;
              use_wd   = 1'b1;
              used_nxt = sat_inc(used_r);
            end
          end
          OP_REG_FREE: begin
            if (use_q) begin
              out_status_nxt = STATUS_BAD_ADDR;
            end else begin
              if (free_r == '0) begin
                head_nxt = cur_r.frame;
              end else begin
                link_we = 1'b1;
                link_wa = tail_r;
                link_wd = cur_r.frame;
              end
              tail_nxt  = cur_r.frame;
              free_nxt  = sat_inc(free_r);
              state_nxt = S_LINK;
            end
          end
          OP_ALLOC: begin
            if (free_r == '0) begin
              out_status_nxt = STATUS_EMPTY;
            end else begin
              use_we                = 1'b1;
              use_wa                = head_r;
              use_wd                = 1'b1;
              head_nxt              = link_q;
              free_nxt              = sat_dec(free_r);
              used_nxt              = sat_inc(used_r);
              out_alloc_address_nxt = ADDR_W'(head_r) << PAGE_SHIFT;
            end
          end
          OP_FREE: begin
            if (!use_q) begin
              out_status_nxt = STATUS_NOT_IN_USE;
            end else begin
              use_we   = 1'b1;
              use_wd   = 1'b0;
              link_we  = 1'b1;
              link_wd  = head_r;
              if (free_r == '0) begin
                tail_nxt = cur_r.frame;
              end
              head_nxt = cur_r.frame;
              free_nxt = sat_inc(free_r);
              used_nxt = sat_dec(used_r);
            end
          end
          default: begin
            out_status_nxt = STATUS_BAD_ADDR;
          end
        endcase
        out_free_count_nxt = free_nxt;
        out_used_count_nxt = used_nxt;
      end
      S_LINK: begin
        link_we   = 1'b1;
        link_wd   = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      clr_r               <= clr_nxt;
      cur_r               <= cur_nxt;
      head_r              <= head_nxt;
      tail_r              <= tail_nxt;
      free_r              <= free_nxt;
      used_r              <= used_nxt;
      out_valid_r         <= out_valid_nxt;
      out_alloc_address_r <= out_alloc_address_nxt;
      out_status_r        <= out_status_nxt;
      out_free_count_r    <= out_free_count_nxt;
      out_used_count_r    <= out_used_count_nxt;
    end
  end

  assign clearing          = (state_r == S_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_alloc_address_r;
  assign out_status        = out_status_r;
  assign out_free_count    = out_free_count_r;
  assign out_used_count    = out_used_count_r;

`ifndef SYNTHESIS
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("back-to-back result strobes");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop) else $error("item taken during clearing pass");
  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_EXEC)) else $error("popped item not executed");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STATUS_OK)) |-> (out_alloc_address_r == '0))
    else $error("address returned with failing status");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator testbench
// Drives register, allocate and free commands through the start/busy port,
// predicts every result with an independent free list model and checks each
// strobed result in order. Runs a directed opener and then random traffic
// under several memory top settings and sender gap rates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pffla_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE  = MODE_W'(3);
  localparam logic [KIND_W-1:0] KIND_SPARE  = KIND_W'(3);
  localparam int                QUIET_LIMIT = 5000;
  localparam int                SHOWN_MAX   = 40;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [KIND_W-1:0] kind;
  } frame_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   alloc_address;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    used_count;
  } frame_result_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode       = '0;
  logic [ADDR_W-1:0]   in_address    = '0;
  logic [KIND_W-1:0]   in_frame_kind = '0;
  logic                cfg_we        = 1'b0;
  logic [TOP_W-1:0]    cfg_data      = '0;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_alloc_address;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_free_count;
  logic [CNT_W-1:0]    out_used_count;

  page_frame_free_list_allocator_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_address        (in_address),
    .in_frame_kind     (in_frame_kind),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_alloc_address (out_alloc_address),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .out_used_count    (out_used_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // free list model
  logic [FRAME_W-1:0] link_mem [FRAMES];
  bit                 in_use_map [FRAMES];
  logic [FRAME_W-1:0] head_frame;
  logic [FRAME_W-1:0] tail_frame;
  logic [CNT_W-1:0]   free_total;
  logic [CNT_W-1:0]   used_total;
  logic [TOP_W-1:0]   top_frame;

  // command planning state, sound use only
  bit         plan_listed [FRAMES];
  bit         plan_held   [FRAMES];
  int         plan_list[$];
  int         plan_held_q[$];
  int         plan_top   = FRAMES;
  int         reg_cursor = 1;

  frame_cmd_t    cmd_backlog[$];
  frame_result_t owed_results[$];
  frame_cmd_t    on_port;
  int            gap_pct      = 0;
  int            items_taken  = 0;
  int            results_seen = 0;
  int            frames_given = 0;
  int            status_tally [4];
  int            errors       = 0;
  int            quiet_cycles = 0;
  string         top_log      = "";

  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(int n);
    return ADDR_W'(n) << PAGE_SHIFT;
  endfunction

  function automatic bit decode_frame(logic [ADDR_W-1:0] a, output logic [FRAME_W-1:0] f);
    logic [ADDR_W-1:0] n;
    n = a >> PAGE_SHIFT;
    f = n[FRAME_W-1:0];
    return (a[PAGE_SHIFT-1:0] == '0) && (n >= 1) && (n < top_frame) && (n < FRAMES);
  endfunction

  function automatic frame_result_t predict_frame_op(frame_cmd_t c);
    frame_result_t      r;
    logic [FRAME_W-1:0] f;
    bit                 ok;
    r = '0;
    r.status = STATUS_OK;
    ok = decode_frame(c.address, f);
    case (c.mode)
      MODE_REGISTER: begin
        if (c.kind == KIND_USED || c.kind == KIND_FREE) begin
          if (!ok || in_use_map[f]) begin
            r.status = STATUS_BAD_ADDR;
          end else if (c.kind == KIND_USED) begin
            in_use_map[f] = 1'b1;
            used_total = count_up(used_total);
          end else begin
            if (free_total == '0) head_frame = f;
            else link_mem[tail_frame] = f;
            tail_frame = f;
            link_mem[f] = '0;
            free_total = count_up(free_total);
          end
        end
      end
      MODE_ALLOC: begin
        if (free_total == '0) begin
          r.status = STATUS_EMPTY;
        end else begin
          f = head_frame;
          head_frame = link_mem[f];
          free_total = count_down(free_total);
          in_use_map[f] = 1'b1;
          used_total = count_up(used_total);
          r.alloc_address = ADDR_W'(f) << PAGE_SHIFT;
        end
      end
      MODE_FREE: begin
        if (!ok) begin
          r.status = STATUS_BAD_ADDR;
        end else if (!in_use_map[f]) begin
          r.status = STATUS_NOT_IN_USE;
        end else begin
          in_use_map[f] = 1'b0;
          used_total = count_down(used_total);
          link_mem[f] = head_frame;
          if (free_total == '0) tail_frame = f;
          head_frame = f;
          free_total = count_up(free_total);
        end
      end
      default: begin
        r.status = STATUS_BAD_ADDR;
      end
    endcase
    r.free_count = free_total;
    r.used_count = used_total;
    return r;
  endfunction

  // queue one command, keeping the plan clear of frames registered twice
  task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                            input logic [KIND_W-1:0] kind);
    int f;
    int i;
    bit ok;
    f = int'(addr >> PAGE_SHIFT);
    ok = (addr[PAGE_SHIFT-1:0] == '0) && (f >= 1) && (f < plan_top) && (f < FRAMES);
    case (mode)
      MODE_REGISTER: begin
        if (ok && plan_listed[f] && (kind == KIND_USED || kind == KIND_FREE))
          kind = $urandom_range(1) ? KIND_RESERVED : KIND_SPARE;
        if (ok && !plan_held[f] && kind == KIND_USED) begin
          plan_held[f] = 1'b1;
          plan_held_q.push_back(f);
        end else if (ok && !plan_held[f] && kind == KIND_FREE) begin
          plan_listed[f] = 1'b1;
          plan_list.push_back(f);
        end
      end
      MODE_ALLOC: begin
        if (plan_list.size() > 0) begin
          f = plan_list.pop_front();
          plan_listed[f] = 1'b0;
          plan_held[f] = 1'b1;
          plan_held_q.push_back(f);
        end
      end
      MODE_FREE: begin
        if (ok && plan_held[f]) begin
          plan_held[f] = 1'b0;
          for (i = 0; i < plan_held_q.size(); i++) begin
            if (plan_held_q[i] == f) begin
              plan_held_q.delete(i);
              break;
            end
          end
          plan_listed[f] = 1'b1;
          plan_list.push_front(f);
        end
      end
      default: ;
    endcase
    cmd_backlog.push_back('{mode, addr, kind});
  endtask

  function automatic logic [ADDR_W-1:0] noise_address(int lim);
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return ADDR_W'($urandom_range(2047)) << PAGE_SHIFT;
      2:       return frame_addr($urandom_range(1023)) | ADDR_W'($urandom_range(4095, 1));
      default: return frame_addr($urandom_range(1) ? lim : lim - 1);
    endcase
  endfunction

  task automatic queue_random_item();
    int              sel;
    int              lim;
    int              r;
    logic [ADDR_W-1:0] a;
    logic [KIND_W-1:0] k;
    lim = (plan_top < FRAMES) ? plan_top : FRAMES;
    sel = $urandom_range(99);
    if (sel < 30) begin
      if ($urandom_range(3) != 0) begin
        if (reg_cursor >= lim) reg_cursor = 1;
        a = frame_addr(reg_cursor);
        reg_cursor++;
      end else begin
        a = noise_address(lim);
      end
      r = $urandom_range(19);
      k = (r < 9) ? KIND_FREE : (r < 15) ? KIND_USED : (r < 18) ? KIND_RESERVED : KIND_SPARE;
      queue_item(MODE_REGISTER, a, k);
    end else if (sel < 62) begin
      queue_item(MODE_ALLOC, $urandom(), KIND_W'($urandom_range(3)));
    end else if (sel < 97) begin
      if (plan_held_q.size() > 0 && $urandom_range(4) != 0)
        a = frame_addr(plan_held_q[$urandom_range(plan_held_q.size() - 1)]);
      else if ($urandom_range(1))
        a = frame_addr($urandom_range(lim));
      else
        a = noise_address(lim);
      queue_item(MODE_FREE, a, KIND_W'($urandom_range(3)));
    end else begin
      queue_item(MODE_SPARE, $urandom(), KIND_W'($urandom_range(3)));
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() > 0 || start || owed_results.size() > 0) @(posedge clk);
  endtask

  task automatic write_top(input int v);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= TOP_W'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    top_frame = TOP_W'(v);
    plan_top  = v;
    top_log   = {top_log, $sformatf(" %0d", v)};
  endtask

  task automatic run_random(input int top, input int gap, input int count);
    write_top(top);
    gap_pct = gap;
    repeat (count) queue_random_item();
  endtask

  task automatic note_error(input string msg);
    if (errors < SHOWN_MAX) $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // driver: hold an item until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_results.push_back(predict_frame_op(on_port));
        items_taken++;
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
          on_port = cmd_backlog.pop_front();
          start         <= 1'b1;
          in_mode       <= on_port.mode;
          in_address    <= on_port.address;
          in_frame_kind <= on_port.kind;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_result_t want;
    bit            bad;
    if (rst_n && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        note_error($sformatf("unexpected result addr=%h status=%0d free=%0d used=%0d",
                             out_alloc_address, out_status, out_free_count, out_used_count));
      end else begin
        want = owed_results.pop_front();
        results_seen++;
        status_tally[want.status]++;
        if (want.alloc_address != '0) frames_given++;
        bad = 1'b0;
        if (out_alloc_address !== want.alloc_address) bad = 1'b1;
        if (out_status !== want.status) bad = 1'b1;
        if (out_free_count !== want.free_count) bad = 1'b1;
        if (out_used_count !== want.used_count) bad = 1'b1;
        if (bad)
          note_error($sformatf({"result %0d: addr %h/%h status %0d/%0d free %0d/%0d ",
                                "used %0d/%0d (got/exp)"}, results_seen,
                               out_alloc_address, want.alloc_address, out_status, want.status,
                               out_free_count, want.free_count, out_used_count,
                               want.used_count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results owed", quiet_cycles,
               owed_results.size());
      $display("page_frame_free_list_allocator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      link_mem[i]   = '0;
      in_use_map[i] = 1'b0;
    end
    head_frame = '0;
    tail_frame = '0;
    free_total = '0;
    used_total = '0;
    top_frame  = TOP_RESET;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_top(8);
    gap_pct = 36;
    queue_item(MODE_ALLOC,    32'h0000_0000, KIND_RESERVED);
    queue_item(MODE_FREE,     32'h0000_0000, KIND_RESERVED);
    queue_item(MODE_FREE,     frame_addr(1), KIND_RESERVED);
    queue_item(MODE_FREE,     32'h0000_1001, KIND_RESERVED);
    queue_item(MODE_FREE,     frame_addr(8), KIND_RESERVED);
    queue_item(MODE_FREE,     32'hFFFF_FFFF, KIND_SPARE);
    queue_item(MODE_SPARE,    frame_addr(2), KIND_FREE);
    queue_item(MODE_REGISTER, frame_addr(1), KIND_RESERVED);
    queue_item(MODE_REGISTER, frame_addr(1), KIND_SPARE);
    queue_item(MODE_REGISTER, frame_addr(1), KIND_USED);
    queue_item(MODE_REGISTER, frame_addr(1), KIND_USED);
    queue_item(MODE_REGISTER, frame_addr(2), KIND_FREE);
    queue_item(MODE_REGISTER, frame_addr(3), KIND_FREE);
    queue_item(MODE_REGISTER, frame_addr(8), KIND_USED);
    queue_item(MODE_REGISTER, 32'h0000_0000, KIND_FREE);
    queue_item(MODE_REGISTER, 32'h0000_2800, KIND_FREE);
    queue_item(MODE_ALLOC,    32'hFFFF_FFFF, KIND_SPARE);
    queue_item(MODE_FREE,     frame_addr(1), KIND_RESERVED);
    queue_item(MODE_ALLOC,    32'h0000_0000, KIND_RESERVED);
    queue_item(MODE_ALLOC,    32'h0000_0000, KIND_RESERVED);
    queue_item(MODE_ALLOC,    32'h0000_0000, KIND_RESERVED);
    queue_item(MODE_FREE,     frame_addr(3), KIND_RESERVED);
    queue_item(MODE_FREE,     frame_addr(2), KIND_RESERVED);
    queue_item(MODE_REGISTER, frame_addr(7), KIND_FREE);
    queue_item(MODE_ALLOC,    32'h0000_0000, KIND_RESERVED);

    run_random(1024, 36, 500);
    run_random(2, 60, 150);
    run_random(1023, 60, 350);
    run_random($urandom_range(1022, 3), 0, 250);
    run_random(1024, 0, 300);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d items and %0d results, %0d frames handed out, memory tops:%s",
             items_taken, results_seen, frames_given, top_log);
    $display("statuses: ok %0d, empty %0d, bad address %0d, not in use %0d; %0d mismatches",
             status_tally[STATUS_OK], status_tally[STATUS_EMPTY],
             status_tally[STATUS_BAD_ADDR], status_tally[STATUS_NOT_IN_USE], errors);
    if (errors == 0) begin
      $display("page_frame_free_list_allocator_unit regression: pass");
    end else begin
      $display("page_frame_free_list_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
